### rtl/kct_pkg.sv
package kct_pkg;

    localparam int NUM_SLOTS_DEF = 8;

    // Slot states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_EXP  = 2'd2;

    // Command codes
    localparam logic [2:0] FN_SET    = 3'd0;
    localparam logic [2:0] FN_CANCEL = 3'd1;
    localparam logic [2:0] FN_ACK    = 3'd2;
    localparam logic [2:0] FN_UPDATE = 3'd3;
    localparam logic [2:0] FN_CLEAR  = 3'd4;
    localparam logic [2:0] FN_QUERY  = 3'd5;
    localparam logic [2:0] FN_RSVD_A = 3'd6;
    localparam logic [2:0] FN_RSVD_B = 3'd7;

    // Error codes
    localparam logic [1:0] ER_OK      = 2'd0;
    localparam logic [1:0] ER_DISABLE = 2'd1;
    localparam logic [1:0] ER_NOSLOT  = 2'd2;
    localparam logic [1:0] ER_NOKEY   = 2'd3;

    localparam logic [31:0] MS_PER_S = 32'd1000;

    // 2^38/1000 rounded up; exact quotient for any 32-bit numerator
    localparam logic [28:0] MS_RECIP    = 29'd274877907;
    localparam int          MS_RECIP_SH = 38;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture the request
        logic scan;      // look at the slot under the scan pointer
        logic clr_ptr;   // restart the scan pointer
        logic div_start; // start the elapsed-time division
        logic upd_wr;    // write back the update of the scanned slot
        logic apply;     // carry out set/cancel/ack/query/clear
        logic emit_exp;  // load an expiry event into the output register
        logic emit_st;   // load the status into the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] func;
        logic       scan_done;
        logic       running;  // scanned slot is running
        logic       div_done;
        logic       expired;  // division result reaches duration
        logic       out_busy;
    } t_stat;

endpackage

### rtl/kct_div.sv
// Divide by 1000: numerator registered, then multiplied by a scaled reciprocal
module kct_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    output logic        o_done,
    output logic [31:0] o_quot
);
    import kct_pkg::*;

    logic [31:0] r_num;
    logic [60:0] r_prod;
    logic        r_mul;

    // Capture the numerator, multiply on the following cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul <= 1'b0;
        end else begin
            r_mul <= i_start;
        end
        if (i_start) begin
            r_num <= i_num;
        end
        if (r_mul) begin
            r_prod <= r_num * MS_RECIP;
        end
    end

    // Quotient is the top of the product
    assign o_done = !r_mul && !i_start;
    assign o_quot = 32'(r_prod[60:MS_RECIP_SH]);
endmodule

### rtl/kct_ctrl.sv
// Command sequencer
module kct_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  kct_pkg::t_stat i_stat,
    output kct_pkg::t_cmd  o_cmd
);
    import kct_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_USCAN = 3'd1;
    localparam logic [2:0] S_UDIV  = 3'd2;
    localparam logic [2:0] S_UEMIT = 3'd3;
    localparam logic [2:0] S_LOOK  = 3'd4;
    localparam logic [2:0] S_APPLY = 3'd5;
    localparam logic [2:0] S_NEXT  = 3'd6;
    localparam logic [2:0] S_STAT  = 3'd7;

    logic [2:0] r_st, n_st;

    always_comb begin
        n_st    = r_st;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_st)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.clr_ptr = 1'b1;
                    n_st = S_LOOK;
                end
            end
            // Lookup sweep: key match, first idle slot
            S_LOOK: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_st = (i_stat.func == FN_UPDATE) ? S_USCAN : S_APPLY;
                    o_cmd.clr_ptr = 1'b1;
                end
            end
            S_APPLY: begin
                o_cmd.apply   = 1'b1;
                o_cmd.clr_ptr = 1'b1;
                n_st = S_NEXT;
            end
            // Update sweep, one slot at a time
            S_USCAN: begin
                if (i_stat.scan_done) begin
                    o_cmd.clr_ptr = 1'b1;
                    n_st = S_NEXT;
                end else if (i_stat.running) begin
                    o_cmd.div_start = 1'b1;
                    n_st = S_UDIV;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_UDIV: begin
                if (i_stat.div_done) begin
                    if (i_stat.expired) begin
                        n_st = S_UEMIT;
                    end else begin
                        o_cmd.upd_wr = 1'b1;
                        o_cmd.scan   = 1'b1;
                        n_st = S_USCAN;
                    end
                end
            end
            S_UEMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.upd_wr   = 1'b1;
                    o_cmd.emit_exp = 1'b1;
                    o_cmd.scan     = 1'b1;
                    n_st = S_USCAN;
                end
            end
            // Next-expiry and count sweep
            S_NEXT: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_st = S_STAT;
                end
            end
            S_STAT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit_st = 1'b1;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
    end
endmodule

### rtl/kct_dp.sv
// Slot table, scan pointer, next-expiry search and output register
module kct_dp #(
    parameter int NUM_SLOTS = kct_pkg::NUM_SLOTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  kct_pkg::t_cmd  i_cmd,
    output kct_pkg::t_stat o_stat,
    input  logic           i_enabled,
    input  logic [2:0]     i_func,
    input  logic [15:0]    i_key,
    input  logic [31:0]    i_duration,
    input  logic [31:0]    i_now_ms,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_kind,
    output logic [1:0]     o_error,
    output logic [2:0]     o_slot,
    output logic [15:0]    o_slot_key,
    output logic [1:0]     o_slot_state,
    output logic [31:0]    o_remaining,
    output logic           o_next_valid,
    output logic [2:0]     o_next_slot,
    output logic [31:0]    o_next_remaining,
    output logic [3:0]     o_active_count,
    output logic           o_last
);
    import kct_pkg::*;

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int PW = $clog2(NUM_SLOTS + 1);

    logic [1:0]  r_status [NUM_SLOTS];
    logic [15:0] r_id     [NUM_SLOTS];
    logic [31:0] r_dur    [NUM_SLOTS];
    logic [31:0] r_rem    [NUM_SLOTS];
    logic [31:0] r_start  [NUM_SLOTS];

    logic [2:0]  r_func;
    logic [15:0] r_key;
    logic [31:0] r_dur_in, r_now;
    logic [PW-1:0] r_ptr;
    logic [IW-1:0] w_idx;

    // Lookup results
    logic          r_fnd_v, r_idl_v;
    logic [IW-1:0] r_fnd, r_idl;
    // Affected slot
    logic          r_sv;
    logic [IW-1:0] r_s;
    logic [1:0]    r_err;
    // Next search
    logic          r_nv;
    logic [IW-1:0] r_ns;
    logic [31:0]   r_nr;
    logic [PW-1:0] r_cnt;
    // Sweep phase flags
    logic          r_nxt_phase;
    logic          r_lookdone_n;

    logic        w_div_done;
    logic [31:0] w_quot;
    logic        w_done;

    assign w_idx  = r_ptr[IW-1:0];
    assign w_done = (r_ptr == PW'(NUM_SLOTS));

    kct_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_now - r_start[w_idx]),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_stat.func      = r_func;
    assign o_stat.scan_done = w_done;
    assign o_stat.running   = !w_done && (r_status[w_idx] == ST_RUN);
    assign o_stat.div_done  = w_div_done;
    assign o_stat.expired   = (w_quot >= r_dur[w_idx]);
    assign o_stat.out_busy  = o_valid && !i_ready;

    // Request capture and scan pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_cmd.clr_ptr) begin
            r_ptr <= '0;
        end else if (i_cmd.scan && !w_done) begin
            r_ptr <= r_ptr + PW'(1);
        end
        if (i_cmd.load) begin
            r_func   <= i_func;
            r_key    <= i_key;
            r_dur_in <= i_duration;
            r_now    <= i_now_ms;
        end
    end

    // Lookup sweep, affected-slot and error bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fnd_v <= 1'b0;
            r_idl_v <= 1'b0;
            r_fnd   <= '0;
            r_idl   <= '0;
            r_sv    <= 1'b0;
            r_s     <= '0;
            r_err   <= ER_OK;
        end else if (i_cmd.scan && !w_done && r_func != FN_UPDATE && !r_nxt_phase) begin
            if (!r_fnd_v && r_status[w_idx] != ST_IDLE && r_id[w_idx] == r_key) begin
                r_fnd_v <= 1'b1;
                r_fnd   <= w_idx;
            end
            if (!r_idl_v && r_status[w_idx] == ST_IDLE) begin
                r_idl_v <= 1'b1;
                r_idl   <= w_idx;
            end
        end
        if (i_cmd.apply) begin
            case (r_func)
                FN_SET: begin
                    if (!i_enabled) begin
                        r_err <= ER_DISABLE;
                    end else if (r_fnd_v && r_status[r_fnd] == ST_RUN) begin
                        r_sv <= 1'b1;
                        r_s  <= r_fnd;
                    end else if (r_idl_v) begin
                        r_sv <= 1'b1;
                        r_s  <= r_idl;
                    end else begin
                        r_err <= ER_NOSLOT;
                    end
                end
                FN_CANCEL, FN_ACK, FN_QUERY: begin
                    r_sv <= r_fnd_v;
                    r_s  <= r_fnd;
                    if (!r_fnd_v) begin
                        r_err <= ER_NOKEY;
                    end
                end
                default: ;
            endcase
        end
    end

    // Marks the next-expiry sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_nxt_phase <= 1'b0;
        end else if (i_cmd.apply || (i_cmd.clr_ptr && r_func == FN_UPDATE && w_done
                                     && !r_lookdone_n)) begin
            r_nxt_phase <= 1'b1;
        end
    end

    // Update command passes through the lookup sweep first; flag its end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_lookdone_n <= 1'b1;
        end else if (i_cmd.clr_ptr && w_done) begin
            r_lookdone_n <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_ptr) begin
            r_nv  <= 1'b0;
            r_ns  <= '0;
            r_nr  <= '0;
            r_cnt <= '0;
        end else if (i_cmd.scan && !w_done && r_nxt_phase) begin
            if (r_status[w_idx] != ST_IDLE) begin
                r_cnt <= r_cnt + PW'(1);
            end
            if (r_status[w_idx] == ST_RUN && (!r_nv || r_rem[w_idx] < r_nr)) begin
                r_nv <= 1'b1;
                r_ns <= w_idx;
                r_nr <= r_rem[w_idx];
            end
        end
    end

    // Slot table writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_status[i] <= ST_IDLE;
            end
        end else if (i_cmd.upd_wr) begin
            if (w_quot >= r_dur[w_idx]) begin
                r_status[w_idx] <= ST_EXP;
            end
        end else if (i_cmd.apply) begin
            case (r_func)
                FN_SET: begin
                    if (i_enabled) begin
                        if (r_fnd_v && r_status[r_fnd] == ST_RUN) begin
                            r_status[r_fnd] <= ST_RUN;
                        end else if (r_idl_v) begin
                            r_status[r_idl] <= ST_RUN;
                        end
                    end
                end
                FN_CANCEL: begin
                    if (r_fnd_v) begin
                        r_status[r_fnd] <= ST_IDLE;
                    end
                end
                FN_ACK: begin
                    if (r_fnd_v && r_status[r_fnd] == ST_EXP) begin
                        r_status[r_fnd] <= ST_IDLE;
                    end
                end
                FN_CLEAR: begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        r_status[i] <= ST_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    // Slot payload writes
    logic          w_set_v;
    logic [IW-1:0] w_set_s;
    always_comb begin
        w_set_v = 1'b0;
        w_set_s = r_idl;
        if (r_fnd_v && r_status[r_fnd] == ST_RUN) begin
            w_set_v = 1'b1;
            w_set_s = r_fnd;
        end else if (r_idl_v) begin
            w_set_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd_wr) begin
            r_rem[w_idx] <= (w_quot >= r_dur[w_idx]) ? 32'd0 : r_dur[w_idx] - w_quot;
        end else if (i_cmd.apply && r_func == FN_SET && i_enabled && w_set_v) begin
            r_id[w_set_s]    <= r_key;
            r_dur[w_set_s]   <= r_dur_in;
            r_rem[w_set_s]   <= r_dur_in;
            r_start[w_set_s] <= r_now;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.emit_exp || i_cmd.emit_st) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
        if (i_cmd.emit_exp) begin
            o_kind           <= 1'b1;
            o_error          <= ER_OK;
            o_slot           <= 3'(w_idx);
            o_slot_key       <= r_id[w_idx];
            o_slot_state     <= ST_EXP;
            o_remaining      <= '0;
            o_next_valid     <= 1'b0;
            o_next_slot      <= '0;
            o_next_remaining <= '0;
            o_active_count   <= '0;
            o_last           <= 1'b0;
        end else if (i_cmd.emit_st) begin
            o_kind           <= 1'b0;
            o_error          <= r_err;
            o_slot           <= r_sv ? 3'(r_s) : 3'd0;
            o_slot_key       <= r_sv ? r_id[r_s] : 16'd0;
            o_slot_state     <= r_sv ? r_status[r_s] : ST_IDLE;
            o_remaining      <= r_sv ? r_rem[r_s] : 32'd0;
            o_next_valid     <= r_nv;
            o_next_slot      <= r_nv ? 3'(r_ns) : 3'd0;
            o_next_remaining <= r_nv ? r_nr : 32'd0;
            o_active_count   <= 4'(r_cnt);
            o_last           <= 1'b1;
        end
    end
endmodule

### rtl/keyed_countdown_timer_table.sv
// Keyed countdown timer table.
// Requests arrive on i_valid/o_ready with func, key, duration and now_ms.
// Results leave on o_valid/i_ready: an update request gives one expiry
// event per timer that runs out, then every request ends with a status
// result (o_last high) carrying next-expiry and active-count.
// Config channel i_cfg_valid/o_cfg_ready writes the enable bit; always ready.
// One request is handled at a time: a lookup sweep over all slots, an
// apply step, a next-expiry sweep over all slots and a status step; a new
// request is taken only once the status is loaded.
// An update replaces the apply step by a sweep that divides the elapsed
// time of each running slot by 1000 and loads an expiry event for each
// slot that runs out.
// Reset makes all slots idle and clears the enable bit.
// A stalled receiver holds the result register; the sequencer waits on it
// before each expiry event and before the status, and no request is taken.
module keyed_countdown_timer_table #(
    parameter int NUM_SLOTS = kct_pkg::NUM_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_enabled,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_func,
    input  logic [15:0] i_key,
    input  logic [31:0] i_duration,
    input  logic [31:0] i_now_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [1:0]  o_error,
    output logic [2:0]  o_slot,
    output logic [15:0] o_slot_key,
    output logic [1:0]  o_slot_state,
    output logic [31:0] o_remaining,
    output logic        o_next_valid,
    output logic [2:0]  o_next_slot,
    output logic [31:0] o_next_remaining,
    output logic [3:0]  o_active_count,
    output logic        o_last
);
    import kct_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  r_enabled;

    assign o_cfg_ready = 1'b1;

    // Enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
        end else if (i_cfg_valid) begin
            r_enabled <= i_cfg_enabled;
        end
    end

    kct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    kct_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_enabled        (r_enabled),
        .i_func           (i_func),
        .i_key            (i_key),
        .i_duration       (i_duration),
        .i_now_ms         (i_now_ms),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_kind           (o_kind),
        .o_error          (o_error),
        .o_slot           (o_slot),
        .o_slot_key       (o_slot_key),
        .o_slot_state     (o_slot_state),
        .o_remaining      (o_remaining),
        .o_next_valid     (o_next_valid),
        .o_next_slot      (o_next_slot),
        .o_next_remaining (o_next_remaining),
        .o_active_count   (o_active_count),
        .o_last           (o_last)
    );

    // No new request while an expiry event is pending
    a_ready_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !(o_valid && !o_last))
        else $error("request taken while events pending");
    // Expiry events are never final
    a_exp_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind) |-> !o_last)
        else $error("expiry marked last");
    // Active count bounded
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_active_count <= 4'(NUM_SLOTS)))
        else $error("active count too large");
endmodule

### sim/kct_checker.sv
module kct_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_enabled,
    input  logic        i_valid,
    input  logic        i_ready,
    input  logic [2:0]  i_func,
    input  logic [15:0] i_key,
    input  logic [31:0] i_duration,
    input  logic [31:0] i_now_ms,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic        i_kind,
    input  logic [1:0]  i_error,
    input  logic [2:0]  i_slot,
    input  logic [15:0] i_slot_key,
    input  logic [1:0]  i_slot_state,
    input  logic [31:0] i_remaining,
    input  logic        i_next_valid,
    input  logic [2:0]  i_next_slot,
    input  logic [31:0] i_next_remaining,
    input  logic [3:0]  i_active_count,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import kct_pkg::*;

    localparam int NS = NUM_SLOTS_DEF;

    typedef struct packed {
        logic        kind;
        logic [1:0]  error;
        logic [2:0]  slot;
        logic [15:0] slot_key;
        logic [1:0]  slot_state;
        logic [31:0] remaining;
        logic        next_valid;
        logic [2:0]  next_slot;
        logic [31:0] next_remaining;
        logic [3:0]  active_count;
        logic        last;
    } t_result;

    // Shadow copy of the timer table
    logic        tbl_enabled;
    logic [1:0]  tbl_state [NS];
    logic [15:0] tbl_key   [NS];
    logic [31:0] tbl_dur   [NS];
    logic [31:0] tbl_rem   [NS];
    logic [31:0] tbl_start [NS];

    t_result expected_results[$];

    function automatic t_result slot_result(logic kind, logic [1:0] err, int s);
        t_result r;
        r = '0;
        r.kind  = kind;
        r.error = err;
        if (s < NS) begin
            r.slot       = 3'(s);
            r.slot_key   = tbl_key[s];
            r.slot_state = tbl_state[s];
            r.remaining  = tbl_rem[s];
        end
        return r;
    endfunction

    function automatic int lookup_key(logic [15:0] key);
        for (int i = 0; i < NS; i++)
            if (tbl_state[i] != ST_IDLE && tbl_key[i] == key) return i;
        return NS;
    endfunction

    // Report one field mismatch; returns 1 when the field differs
    function automatic logic field_bad(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one request to the shadow table and queue its results
    task automatic predict_request(logic [2:0] func, logic [15:0] key,
                                   logic [31:0] dur, logic [31:0] now);
        logic [1:0]  err;
        int          s;
        int          f;
        logic [31:0] el;
        t_result     r;
        logic        nv;
        logic [2:0]  nslot;
        logic [31:0] nrem;
        logic [3:0]  cnt;
        err = ER_OK;
        s = NS;
        case (func)
            FN_SET: begin
                if (!tbl_enabled) begin
                    err = ER_DISABLE;
                end else begin
                    f = lookup_key(key);
                    if (f < NS && tbl_state[f] == ST_RUN) begin
                        s = f;
                    end else begin
                        for (int i = 0; i < NS; i++)
                            if (s == NS && tbl_state[i] == ST_IDLE) s = i;
                    end
                    if (s < NS) begin
                        tbl_key[s] = key;
                        tbl_dur[s] = dur;
                        tbl_rem[s] = dur;
                        tbl_start[s] = now;
                        tbl_state[s] = ST_RUN;
                    end else begin
                        err = ER_NOSLOT;
                    end
                end
            end
            FN_CANCEL, FN_ACK, FN_QUERY: begin
                s = lookup_key(key);
                if (s >= NS) err = ER_NOKEY;
                else if (func == FN_CANCEL || (func == FN_ACK && tbl_state[s] == ST_EXP))
                    tbl_state[s] = ST_IDLE;
            end
            FN_UPDATE: begin
                for (int i = 0; i < NS; i++) begin
                    if (tbl_state[i] == ST_RUN) begin
                        el = (now - tbl_start[i]) / MS_PER_S;
                        if (el >= tbl_dur[i]) begin
                            tbl_rem[i] = '0;
                            tbl_state[i] = ST_EXP;
                            expected_results.insert(expected_results.size(),
                                                    slot_result(1'b1, ER_OK, i));
                        end else begin
                            tbl_rem[i] = tbl_dur[i] - el;
                        end
                    end
                end
            end
            FN_CLEAR: begin
                for (int i = 0; i < NS; i++) tbl_state[i] = ST_IDLE;
            end
            default: ;
        endcase
        // Next-expiry and active count
        nv = 1'b0; nslot = '0; nrem = '0; cnt = '0;
        for (int i = 0; i < NS; i++) begin
            if (tbl_state[i] != ST_IDLE) cnt++;
            if (tbl_state[i] == ST_RUN && (!nv || tbl_rem[i] < nrem)) begin
                nv = 1'b1; nslot = 3'(i); nrem = tbl_rem[i];
            end
        end
        r = slot_result(1'b0, err, s);
        r.next_valid = nv;
        r.next_slot = nslot;
        r.next_remaining = nrem;
        r.active_count = cnt;
        r.last = 1'b1;
        expected_results.insert(expected_results.size(), r);
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result exp_r;
        logic    bad;
        if (!i_rst_n) begin
            tbl_enabled <= 1'b0;
            for (int i = 0; i < NS; i++) begin
                tbl_state[i] = ST_IDLE;
                tbl_key[i] = '0; tbl_dur[i] = '0; tbl_rem[i] = '0; tbl_start[i] = '0;
            end
            expected_results.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) tbl_enabled <= i_cfg_enabled;
            if (i_valid && i_ready) predict_request(i_func, i_key, i_duration, i_now_ms);
            if (i_res_valid && i_res_ready) begin
                got = '{i_kind, i_error, i_slot, i_slot_key, i_slot_state, i_remaining,
                        i_next_valid, i_next_slot, i_next_remaining, i_active_count,
                        i_last};
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    bad = 1'b0;
                    bad |= field_bad("kind", 32'(exp_r.kind), 32'(got.kind));
                    bad |= field_bad("error", 32'(exp_r.error), 32'(got.error));
                    bad |= field_bad("slot", 32'(exp_r.slot), 32'(got.slot));
                    bad |= field_bad("slot_key", 32'(exp_r.slot_key), 32'(got.slot_key));
                    bad |= field_bad("slot_state", 32'(exp_r.slot_state),
                                     32'(got.slot_state));
                    bad |= field_bad("remaining", exp_r.remaining, got.remaining);
                    bad |= field_bad("next_valid", 32'(exp_r.next_valid),
                                     32'(got.next_valid));
                    bad |= field_bad("next_slot", 32'(exp_r.next_slot), 32'(got.next_slot));
                    bad |= field_bad("next_remaining", exp_r.next_remaining,
                                     got.next_remaining);
                    bad |= field_bad("active_count", 32'(exp_r.active_count),
                                     32'(got.active_count));
                    bad |= field_bad("last", 32'(exp_r.last), 32'(got.last));
                    if (bad) o_fail_count <= o_fail_count + 1;
                end
            end
        end
        o_pending <= expected_results.size();
    end
endmodule

### sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kct_pkg::*;

    localparam int WATCHDOG = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_enabled = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_func = '0;
    logic [15:0] i_key = '0;
    logic [31:0] i_duration = '0;
    logic [31:0] i_now_ms = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_kind;
    logic [1:0]  o_error;
    logic [2:0]  o_slot;
    logic [15:0] o_slot_key;
    logic [1:0]  o_slot_state;
    logic [31:0] o_remaining;
    logic        o_next_valid;
    logic [2:0]  o_next_slot;
    logic [31:0] o_next_remaining;
    logic [3:0]  o_active_count;
    logic        o_last;

    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    int          burst_left = 0;
    logic        hold_off = 1'b0;
    logic [31:0] clock_ms = 32'd0;
    logic [15:0] key_pool [8];

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    keyed_countdown_timer_table u_dut (.*);

    kct_checker u_checker (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_enabled,
        .i_valid, .i_ready(o_ready), .i_func, .i_key, .i_duration, .i_now_ms,
        .i_res_valid(o_valid), .i_res_ready(i_ready),
        .i_kind(o_kind), .i_error(o_error), .i_slot(o_slot), .i_slot_key(o_slot_key),
        .i_slot_state(o_slot_state), .i_remaining(o_remaining),
        .i_next_valid(o_next_valid), .i_next_slot(o_next_slot),
        .i_next_remaining(o_next_remaining), .i_active_count(o_active_count),
        .i_last(o_last), .o_fail_count(fail_count), .o_pending(pending)
    );

    // Watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver stall pattern, with a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_off) i_ready <= 1'b0;
        else if ($urandom_range(0, 3) == 0) i_ready <= 1'($urandom_range(0, 1));
        else i_ready <= ($urandom_range(0, 9) != 0);
    end

    // Offer one request and hold it until taken; valid is left high
    task automatic send_request(logic [2:0] func, logic [15:0] key,
                                logic [31:0] dur, logic [31:0] now);
        i_valid    <= 1'b1;
        i_func     <= func;
        i_key      <= key;
        i_duration <= dur;
        i_now_ms   <= now;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // Wait until every result is in, let the block settle, then write the enable bit
    task automatic drain_and_write(logic en);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        i_cfg_valid   <= 1'b1;
        i_cfg_enabled <= en;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_request();
        logic [2:0]  func;
        logic [15:0] key;
        logic [31:0] dur;
        int          pick;
        pick = $urandom_range(0, 99);
        key  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : key_pool[$urandom_range(0, 7)];
        dur  = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 40));
        if (pick < 35)      func = FN_SET;
        else if (pick < 60) func = FN_UPDATE;
        else if (pick < 70) func = FN_CANCEL;
        else if (pick < 80) func = FN_ACK;
        else if (pick < 93) func = FN_QUERY;
        else if (pick < 96) func = FN_CLEAR;
        else                func = ($urandom_range(0, 1) == 0) ? FN_RSVD_A : FN_RSVD_B;
        // Time mostly advances a few seconds; sometimes jumps anywhere
        if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(0, 8000);
        send_request(func, key, dur, clock_ms);
    endtask

    initial begin
        for (int i = 0; i < 8; i++) key_pool[i] = 16'($urandom);
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: set while disabled, then enable
        send_request(FN_SET, 16'h1234, 32'd5, 32'd0);
        drain_and_write(1'b1);
        send_request(FN_QUERY, 16'h1234, '0, '0);
        send_request(FN_SET, 16'h0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_request(FN_SET, 16'hFFFF, 32'd0, 32'd0);
        send_request(FN_SET, 16'h00AA, 32'd3, 32'd1000);
        send_request(FN_SET, 16'h00AA, 32'd10, 32'd2000);
        send_request(FN_UPDATE, '0, '0, 32'd5000);
        send_request(FN_ACK, 16'h00AA, '0, '0);
        send_request(FN_ACK, 16'hFFFF, '0, '0);
        send_request(FN_SET, 16'hFFFF, 32'd1, 32'd0);
        send_request(FN_QUERY, 16'hFFFF, '0, '0);
        send_request(FN_CANCEL, 16'h00AA, '0, '0);
        send_request(FN_CANCEL, 16'h5555, '0, '0);
        for (int i = 0; i < 8; i++) send_request(FN_SET, 16'(i + 16'h100), 32'(i), 32'd0);
        send_request(FN_UPDATE, '0, '0, 32'hFFFF_FFFF);
        send_request(FN_RSVD_A, '1, '1, '1);
        send_request(FN_RSVD_B, '0, '0, '0);
        send_request(FN_CLEAR, '0, '0, '0);

        // Random phases, with the enable bit cleared in phase 1 only
        for (int phase = 0; phase < 4; phase++) begin
            drain_and_write(phase != 1);
            if (phase == 2) begin
                hold_off = 1'b1;
                fork
                    begin repeat (400) @(negedge i_clk); hold_off = 1'b0; end
                    for (int n = 0; n < 10; n++) random_request();
                join
            end
            // Bursts of random length with random gaps
            for (int n = 0; n < 100; n++) begin
                if (burst_left == 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 30)) @(negedge i_clk);
                    burst_left = $urandom_range(1, 12);
                end
                burst_left = burst_left - 1;
                random_request();
            end
        end

        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (fail_count == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
